// ===== rtl/dual_number_alu_defines.svh =====
// Assertion macros shared by the dual-number ALU RTL.
`ifndef DUAL_NUMBER_ALU_DEFINES_SVH
`define DUAL_NUMBER_ALU_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define DNA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dual_number_alu assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define DNA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dual_number_alu assertion failed");

`endif

// ===== rtl/dna_pkg.sv =====
// Types, constants and helper functions of the dual-number ALU.
`default_nettype none
package dna_pkg;

  // Default number of fraction bits of every operand and result part.
  localparam int FRAC_BITS_DEF = 16;
  // Quotient bits produced by the divider chain, one per cell (includes a rounding bit).
  localparam int QUOT_BITS = 35;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] a_real;
    logic signed [31:0] a_dual;
    logic signed [31:0] b_real;
    logic signed [31:0] b_dual;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_dual;
    logic               divide_by_zero;
    logic               overflow;
  } out_word_t;

  // One division lane: partial remainder, divisor, dividend bits still to shift in.
  typedef struct packed {
    logic [63:0]          rem;
    logic [63:0]          den;
    logic [QUOT_BITS-1:0] lo;
    logic [QUOT_BITS-1:0] quo;
    logic                 neg;
    logic                 ovf;
  } lane_t;

  // Word carried along the cell chain.
  typedef struct packed {
    op_e         op;
    logic        dz;
    lane_t       re;
    lane_t       du;
    logic [31:0] fix_real;
    logic [31:0] fix_dual;
    logic        fix_ovf;
  } cell_t;

  // Saturate a sign and magnitude to 32 bits; bit 32 of the result is the overflow flag.
  function automatic logic [32:0] sat_pack(input logic neg, input logic [64:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (mag > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end else begin
      if (mag > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, ~mag[31:0] + 32'd1};
    end
    return r;
  endfunction

  // Magnitude of a signed 65-bit value.
  function automatic logic [64:0] mag65(input logic signed [64:0] v);
    logic [64:0] m;
    m = v[64] ? 65'(-v) : 65'(v);
    return m;
  endfunction

  // Saturate a signed 65-bit value to 32 bits with overflow flag in bit 32.
  function automatic logic [32:0] sat_signed(input logic signed [64:0] v);
    logic [32:0] r;
    r = sat_pack(v[64], mag65(v));
    return r;
  endfunction

  // Round the lane quotient, which carries one extra rounding bit, and saturate it.
  function automatic logic [32:0] div_pack(input lane_t l);
    logic [QUOT_BITS:0] q1;
    logic [32:0]        r;
    q1 = {1'b0, l.quo} + (QUOT_BITS+1)'(1);
    if (l.ovf) r = l.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    else r = sat_pack(l.neg, 65'(q1[QUOT_BITS:1]));
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dna_prep.sv =====
// Front end: operand products, add/sub/multiply results and divider set-up.
`default_nettype none
module dna_prep #(
  parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire dna_pkg::in_word_t word_i,
  output logic                  valid_o,
  output dna_pkg::cell_t        cell_o
);

  localparam int Q   = dna_pkg::QUOT_BITS;
  localparam int SHR = dna_pkg::QUOT_BITS - 1 - FRAC_BITS;

  typedef struct packed {
    dna_pkg::op_e       op;
    logic signed [31:0] ar;
    logic signed [31:0] ad;
    logic signed [31:0] br;
    logic signed [31:0] bd;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ab;
    logic signed [63:0] p_ba;
    logic [63:0]        sq;
    logic [31:0]        ma;
    logic [31:0]        mb;
  } prod_t;

  prod_t          a_d, a_q;
  logic           a_vld_q;
  dna_pkg::cell_t b_d, b_q;
  logic           b_vld_q;

  // Set up one division lane: split the scaled dividend and check the quotient range.
  function automatic dna_pkg::lane_t make_lane(input logic [63:0] num, input logic [63:0] den,
                                               input logic neg);
    dna_pkg::lane_t l;
    logic [63+Q:0]  sh;
    sh    = {num, {Q{1'b0}}} >> SHR;
    l.den = den;
    l.neg = neg;
    l.ovf = sh[63+Q:Q] >= den;
    l.rem = sh[63+Q:Q];
    l.lo  = sh[Q-1:0];
    l.quo = '0;
    return l;
  endfunction

  // First stage: the four products.
  always_comb begin
    a_d.op   = dna_pkg::op_e'(word_i.operation);
    a_d.ar   = word_i.a_real;
    a_d.ad   = word_i.a_dual;
    a_d.br   = word_i.b_real;
    a_d.bd   = word_i.b_dual;
    a_d.ma   = word_i.a_real[31] ? 32'(-word_i.a_real) : 32'(word_i.a_real);
    a_d.mb   = word_i.b_real[31] ? 32'(-word_i.b_real) : 32'(word_i.b_real);
    a_d.p_rr = word_i.a_real * word_i.b_real;
    a_d.p_ab = word_i.a_real * word_i.b_dual;
    a_d.p_ba = word_i.b_real * word_i.a_dual;
    a_d.sq   = 64'(a_d.mb) * 64'(a_d.mb);
  end

  // Second stage: finished add/sub/multiply parts and divider start values.
  always_comb begin
    logic signed [32:0] s_r, s_d;
    logic signed [64:0] m_d, dv;
    logic [64:0]        m, rnd;
    logic [32:0]        pr, pd;
    logic [64:0]        nd;
    rnd = 65'(1) << (FRAC_BITS - 1);
    s_r = '0;
    s_d = '0;
    m_d = '0;
    m   = '0;
    pr  = '0;
    pd  = '0;
    case (a_q.op)
      dna_pkg::OP_ADD: begin
        s_r = 33'(a_q.ar) + 33'(a_q.br);
        s_d = 33'(a_q.ad) + 33'(a_q.bd);
        pr  = dna_pkg::sat_signed(65'(s_r));
        pd  = dna_pkg::sat_signed(65'(s_d));
      end
      dna_pkg::OP_SUB: begin
        s_r = 33'(a_q.ar) - 33'(a_q.br);
        s_d = 33'(a_q.ad) - 33'(a_q.bd);
        pr  = dna_pkg::sat_signed(65'(s_r));
        pd  = dna_pkg::sat_signed(65'(s_d));
      end
      dna_pkg::OP_MUL: begin
        m   = dna_pkg::mag65(65'(a_q.p_rr));
        pr  = dna_pkg::sat_pack(a_q.p_rr[63], (m + rnd) >> FRAC_BITS);
        m_d = 65'(a_q.p_ab) + 65'(a_q.p_ba);
        m   = dna_pkg::mag65(m_d);
        pd  = dna_pkg::sat_pack(m_d[64], (m + rnd) >> FRAC_BITS);
      end
      default: begin
      end
    endcase
    dv  = 65'(a_q.p_ba) - 65'(a_q.p_ab);
    nd  = dna_pkg::mag65(dv);
    b_d.op       = a_q.op;
    b_d.dz       = (a_q.op == dna_pkg::OP_DIV) && (a_q.br == 32'sd0);
    b_d.re       = make_lane(64'(a_q.ma), 64'(a_q.mb), a_q.ar[31] ^ a_q.br[31]);
    b_d.du       = make_lane(nd[63:0], a_q.sq, dv[64]);
    b_d.fix_real = pr[31:0];
    b_d.fix_dual = pd[31:0];
    b_d.fix_ovf  = pr[32] | pd[32];
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign valid_o = b_vld_q;
  assign cell_o  = b_q;

endmodule
`default_nettype wire

// ===== rtl/dna_cell.sv =====
// One divider cell: a restoring step on the real and the dual lane.
`default_nettype none
module dna_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire dna_pkg::cell_t cell_i,
  output logic                valid_o,
  output dna_pkg::cell_t      cell_o
);

  localparam int Q = dna_pkg::QUOT_BITS;

  dna_pkg::cell_t cell_d, cell_q;
  logic           vld_q;

  // Shift in the next dividend bit, subtract when it fits, record the quotient bit.
  function automatic dna_pkg::lane_t step(input dna_pkg::lane_t l);
    dna_pkg::lane_t n;
    logic [63:0]    t;
    logic           ge;
    t     = {l.rem[62:0], l.lo[Q-1]};
    ge    = t >= l.den;
    n     = l;
    n.rem = ge ? t - l.den : t;
    n.lo  = {l.lo[Q-2:0], 1'b0};
    n.quo = {l.quo[Q-2:0], ge};
    return n;
  endfunction

  always_comb begin
    cell_d    = cell_i;
    cell_d.re = step(cell_i.re);
    cell_d.du = step(cell_i.du);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = vld_q;
  assign cell_o  = cell_q;

endmodule
`default_nettype wire

// ===== rtl/dual_number_alu.sv =====
// Dual-number ALU top level: front end, divider cell chain, output and skid registers.
//
// Input channel: in_word_i carries the operation and the four operand parts; a word is
// taken at a clock edge where in_valid_i is high and in_stall_o is low. Output channel:
// out_word_o carries both result parts and the divide-by-zero and overflow flags; it is
// taken where out_valid_o is high and out_stall_i is low.
// Every operation has the same latency: the result passes two front-end stages, one cell
// per quotient bit of the 35-cell divider chain and one output stage. One word per cycle is
// accepted while the skid register is empty, set by the chain advancing one cell per clock.
// Results leave in input order.
// When the receiver stalls, the output register holds its word and the next finished word
// drops into a one-entry skid register; while that register is full the whole pipeline
// and the input channel stall. Reset clears all valid bits; the unit keeps no other state.
`default_nettype none
`include "dual_number_alu_defines.svh"
module dual_number_alu #(
  parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dna_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dna_pkg::out_word_t     out_word_o
);

  localparam int NC = dna_pkg::QUOT_BITS;

  logic               en;
  logic               vld   [NC+1];
  dna_pkg::cell_t     cw    [NC+1];
  dna_pkg::out_word_t fin;
  dna_pkg::out_word_t out_q, skid_q;
  logic               out_vld_q, skid_vld_q;
  logic               out_free;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  dna_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (vld[0]),
    .cell_o  (cw[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    dna_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[k]),
      .cell_i  (cw[k]),
      .valid_o (vld[k+1]),
      .cell_o  (cw[k+1])
    );
  end

  // Final rounding and saturation of the word leaving the chain.
  always_comb begin
    logic [32:0] pr, pd;
    pr = dna_pkg::div_pack(cw[NC].re);
    pd = dna_pkg::div_pack(cw[NC].du);
    if (cw[NC].op != dna_pkg::OP_DIV) begin
      fin.res_real       = cw[NC].fix_real;
      fin.res_dual       = cw[NC].fix_dual;
      fin.divide_by_zero = 1'b0;
      fin.overflow       = cw[NC].fix_ovf;
    end else if (cw[NC].dz) begin
      fin.res_real       = '0;
      fin.res_dual       = '0;
      fin.divide_by_zero = 1'b1;
      fin.overflow       = 1'b0;
    end else begin
      fin.res_real       = pr[31:0];
      fin.res_dual       = pd[31:0];
      fin.divide_by_zero = 1'b0;
      fin.overflow       = pr[32] | pd[32];
    end
  end

  assign out_free = !out_vld_q || !out_stall_i;

  // Output and skid valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        skid_vld_q <= 1'b0;
        out_vld_q  <= 1'b1;
      end
    end else if (vld[NC]) begin
      if (out_free) out_vld_q <= 1'b1;
      else skid_vld_q <= 1'b1;
    end else if (out_free) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output and skid payloads.
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) out_q <= skid_q;
    end else if (vld[NC]) begin
      if (out_free) out_q <= fin;
      else skid_q <= fin;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // A full skid register always sits behind a valid output word.
  `DNA_ASSERT_IMPL(a_skid_behind_out, skid_vld_q, out_vld_q)
  // The skid register fills only from a cycle where the output was stalled.
  `DNA_ASSERT_IMPL(a_skid_fill, $rose(skid_vld_q), $past(out_vld_q && out_stall_i))
  // A divide-by-zero word carries zero parts and no overflow.
  `DNA_ASSERT_IMPL(a_dz_word, out_valid_o && out_word_o.divide_by_zero,
    !out_word_o.overflow && (out_word_o.res_real == 32'sd0) && (out_word_o.res_dual == 32'sd0))

endmodule
`default_nettype wire
